[rtl/bmlp_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bmlp_pkg: shared definitions for the binarized mlp packet classifier
// network sizes, field widths, table codes, sequencer states and the
// structs that link the table store to the sequencer
// ----------------------------------------------------------------------------
package bmlp_pkg;

  localparam int FEATURE_COUNT = 10;
  localparam int HIDDEN_COUNT  = 64;

  // widest activation vector seen by the shared neuron unit
  localparam int VEC_W = (FEATURE_COUNT > HIDDEN_COUNT) ? FEATURE_COUNT : HIDDEN_COUNT;
  localparam int FEAT_IDX_W = (FEATURE_COUNT > 1) ? $clog2(FEATURE_COUNT) : 1;
  localparam int HID_IDX_W  = (HIDDEN_COUNT > 1) ? $clog2(HIDDEN_COUNT) : 1;
  localparam int HID_CNT_W  = $clog2(HIDDEN_COUNT + 1);
  localparam int CNT_W      = $clog2(VEC_W + 1);
  localparam int DOT_W      = 9;

  localparam int SEL_W   = 3;
  localparam int ENTRY_W = 6;
  localparam int VALUE_W = 64;
  localparam int FIELD_W = 16;
  localparam int FTHR_W  = 17;
  localparam int THR_W   = 8;
  localparam int SCORE_W = 8;
  localparam int COUNT_W = 32;

  localparam logic ACTION_CLASSIFY = 1'b0;
  localparam logic ACTION_WRITE    = 1'b1;

  typedef enum logic [SEL_W-1:0] {
    TBL_FEAT_THR = 3'd0,
    TBL_L1_W     = 3'd1,
    TBL_L2_W     = 3'd2,
    TBL_OUT_W    = 3'd3,
    TBL_L1_THR   = 3'd4,
    TBL_L2_THR   = 3'd5
  } table_sel_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FEAT,
    ST_L1,
    ST_L2,
    ST_OUT,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic               en;
    logic [SEL_W-1:0]   sel;
    logic [ENTRY_W-1:0] idx;
    logic [VALUE_W-1:0] value;
  } tbl_wr_t;

  typedef struct packed {
    logic                 layer2;
    logic [HID_IDX_W-1:0] addr;
  } tbl_rd_t;

  typedef struct packed {
    logic [VEC_W-1:0] weight;
    logic [THR_W-1:0] thr;
  } row_t;

  // clamp a raw entry to the feature threshold width
  function automatic logic [FTHR_W-1:0] sat_feat(input logic [VALUE_W-1:0] v);
    logic [FTHR_W-1:0] r;
    if (|v[VALUE_W-1:FTHR_W]) r = '1;
    else r = v[FTHR_W-1:0];
    return r;
  endfunction

  // clamp a two's complement entry to -128..127
  function automatic logic [THR_W-1:0] sat_thr(input logic [VALUE_W-1:0] v);
    logic [THR_W-1:0] r;
    if (v[VALUE_W-1]) begin
      if (&v[VALUE_W-2:THR_W-1]) r = v[THR_W-1:0];
      else r = {1'b1, {(THR_W-1){1'b0}}};
    end else begin
      if (|v[VALUE_W-2:THR_W-1]) r = {1'b0, {(THR_W-1){1'b1}}};
      else r = v[THR_W-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[rtl/bmlp_tables.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bmlp_tables: model table store
// feature thresholds and output weights in flops, hidden layer rows in
// memories with per-entry valid bits, one registered row read per cycle
// ----------------------------------------------------------------------------
module bmlp_tables (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire bmlp_pkg::tbl_wr_t    wr,
  input  wire bmlp_pkg::tbl_rd_t    rd,
  output logic [bmlp_pkg::FEATURE_COUNT-1:0][bmlp_pkg::FTHR_W-1:0] feat_thr,
  output logic [bmlp_pkg::HIDDEN_COUNT-1:0] out_weight,
  output bmlp_pkg::row_t            row
);

  logic [bmlp_pkg::FEATURE_COUNT-1:0] l1w_mem [bmlp_pkg::HIDDEN_COUNT];
  logic [bmlp_pkg::HIDDEN_COUNT-1:0]  l2w_mem [bmlp_pkg::HIDDEN_COUNT];
  logic [bmlp_pkg::THR_W-1:0]         l1t_mem [bmlp_pkg::HIDDEN_COUNT];
  logic [bmlp_pkg::THR_W-1:0]         l2t_mem [bmlp_pkg::HIDDEN_COUNT];

  logic [bmlp_pkg::HIDDEN_COUNT-1:0] l1w_vld, l2w_vld, l1t_vld, l2t_vld;

  logic [bmlp_pkg::FEATURE_COUNT-1:0] l1w_rd;
  logic [bmlp_pkg::HIDDEN_COUNT-1:0]  l2w_rd;
  logic [bmlp_pkg::THR_W-1:0]         l1t_rd, l2t_rd;
  logic l1w_rv, l2w_rv, l1t_rv, l2t_rv;
  logic layer2;

  logic hid_ok, feat_ok;
  logic we_feat, we_l1w, we_l2w, we_out, we_l1t, we_l2t;
  logic [bmlp_pkg::HID_IDX_W-1:0]  waddr;
  logic [bmlp_pkg::FEAT_IDX_W-1:0] faddr;

  assign hid_ok  = {1'b0, wr.idx} < (bmlp_pkg::ENTRY_W+1)'(bmlp_pkg::HIDDEN_COUNT);
  assign feat_ok = {1'b0, wr.idx} < (bmlp_pkg::ENTRY_W+1)'(bmlp_pkg::FEATURE_COUNT);
  assign waddr   = wr.idx[bmlp_pkg::HID_IDX_W-1:0];
  assign faddr   = wr.idx[bmlp_pkg::FEAT_IDX_W-1:0];

  always_comb begin
    we_feat = 1'b0;
    we_l1w  = 1'b0;
    we_l2w  = 1'b0;
    we_out  = 1'b0;
    we_l1t  = 1'b0;
    we_l2t  = 1'b0;
    unique case (wr.sel)
      bmlp_pkg::TBL_FEAT_THR: we_feat = wr.en && feat_ok;
      bmlp_pkg::TBL_L1_W:     we_l1w  = wr.en && hid_ok;
      bmlp_pkg::TBL_L2_W:     we_l2w  = wr.en && hid_ok;
      bmlp_pkg::TBL_OUT_W:    we_out  = wr.en && (wr.idx == '0);
      bmlp_pkg::TBL_L1_THR:   we_l1t  = wr.en && hid_ok;
      bmlp_pkg::TBL_L2_THR:   we_l2t  = wr.en && hid_ok;
      default: ;
    endcase
  end

  // small tables in flops, cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      feat_thr   <= '0;
      out_weight <= '0;
    end else begin
      if (we_feat) feat_thr[faddr] <= bmlp_pkg::sat_feat(wr.value);
      if (we_out) out_weight <= wr.value[bmlp_pkg::HIDDEN_COUNT-1:0];
    end
  end

  // row memories
  always_ff @(posedge clk) begin
    if (we_l1w) l1w_mem[waddr] <= wr.value[bmlp_pkg::FEATURE_COUNT-1:0];
    if (we_l2w) l2w_mem[waddr] <= wr.value[bmlp_pkg::HIDDEN_COUNT-1:0];
    if (we_l1t) l1t_mem[waddr] <= bmlp_pkg::sat_thr(wr.value);
    if (we_l2t) l2t_mem[waddr] <= bmlp_pkg::sat_thr(wr.value);
    l1w_rd <= l1w_mem[rd.addr];
    l2w_rd <= l2w_mem[rd.addr];
    l1t_rd <= l1t_mem[rd.addr];
    l2t_rd <= l2t_mem[rd.addr];
  end

  // valid bits stand in for clearing the memories
  always_ff @(posedge clk) begin
    if (rst) begin
      l1w_vld <= '0;
      l2w_vld <= '0;
      l1t_vld <= '0;
      l2t_vld <= '0;
      l1w_rv  <= 1'b0;
      l2w_rv  <= 1'b0;
      l1t_rv  <= 1'b0;
      l2t_rv  <= 1'b0;
      layer2  <= 1'b0;
    end else begin
      if (we_l1w) l1w_vld[waddr] <= 1'b1;
      if (we_l2w) l2w_vld[waddr] <= 1'b1;
      if (we_l1t) l1t_vld[waddr] <= 1'b1;
      if (we_l2t) l2t_vld[waddr] <= 1'b1;
      l1w_rv <= l1w_vld[rd.addr];
      l2w_rv <= l2w_vld[rd.addr];
      l1t_rv <= l1t_vld[rd.addr];
      l2t_rv <= l2t_vld[rd.addr];
      layer2 <= rd.layer2;
    end
  end

  always_comb begin
    if (layer2) begin
      row.weight = l2w_rv ? bmlp_pkg::VEC_W'(l2w_rd) : '0;
      row.thr    = l2t_rv ? l2t_rd : '0;
    end else begin
      row.weight = l1w_rv ? bmlp_pkg::VEC_W'(l1w_rd) : '0;
      row.thr    = l1t_rv ? l1t_rd : '0;
    end
  end

endmodule
`default_nettype wire

[rtl/bmlp_neuron.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bmlp_neuron: shared xnor-popcount neuron
// dot product over the low bits_used bits and a strict threshold compare
// ----------------------------------------------------------------------------
module bmlp_neuron (
  input  wire logic [bmlp_pkg::VEC_W-1:0]        act,
  input  wire logic [bmlp_pkg::VEC_W-1:0]        weight,
  input  wire logic [bmlp_pkg::CNT_W-1:0]        bits_used,
  input  wire logic signed [bmlp_pkg::THR_W-1:0] thr,
  output logic signed [bmlp_pkg::DOT_W-1:0]      dot,
  output logic                                   fire
);

  localparam int GROUPS = (bmlp_pkg::VEC_W + 7) / 8;
  localparam int PAD_W  = GROUPS * 8;

  logic [PAD_W-1:0]             agree;
  logic [3:0]                   grp [GROUPS];
  logic [bmlp_pkg::CNT_W-1:0]   pop;
  logic [bmlp_pkg::DOT_W-1:0]   dot_raw;
  logic signed [bmlp_pkg::DOT_W-1:0] thr_ext;

  always_comb begin
    agree = '0;
    for (int i = 0; i < bmlp_pkg::VEC_W; i++) begin
      agree[i] = ~(act[i] ^ weight[i]) && (bmlp_pkg::CNT_W'(i) < bits_used);
    end
  end

  // two-level count: bytes, then byte counts
  always_comb begin
    for (int g = 0; g < GROUPS; g++) begin
      grp[g] = '0;
      for (int b = 0; b < 8; b++) begin
        grp[g] = grp[g] + 4'(agree[g*8+b]);
      end
    end
  end

  always_comb begin
    pop = '0;
    for (int g = 0; g < GROUPS; g++) begin
      pop = pop + bmlp_pkg::CNT_W'(grp[g]);
    end
  end

  assign dot_raw = (bmlp_pkg::DOT_W'(pop) << 1) - bmlp_pkg::DOT_W'(bits_used);
  assign dot     = signed'(dot_raw);
  assign thr_ext = bmlp_pkg::DOT_W'(thr);
  assign fire    = dot > thr_ext;

endmodule
`default_nettype wire

[rtl/binarized_mlp_packet_classifier.sv]
`default_nettype none
// sequencing: a classify transaction of an IPv4 packet passes through the feature,
//   layer one, layer two, output and finish states before its result shows; write and
//   non-IPv4 transactions go from idle straight to the finish state
// throughput: a new transaction is taken only in the idle state; the shared neuron
//   unit evaluates one hidden neuron per cycle from one memory row read
// reset: synchronous, clears sequencer, counters and all model tables (valid bits,
//   no clearing pass); ready rises on the first cycle after reset
// ----------------------------------------------------------------------------
// binarized_mlp_packet_classifier: binarized two-layer mlp packet classifier
// loads model tables from write transactions and classifies IPv4 packets
// through an xnor-popcount network evaluated by one shared neuron unit
// ----------------------------------------------------------------------------
module binarized_mlp_packet_classifier (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // item channel
  input  wire logic                          item_valid,
  output logic                               item_ready,
  input  wire logic                          action,
  input  wire logic [bmlp_pkg::SEL_W-1:0]    table_select,
  input  wire logic [bmlp_pkg::ENTRY_W-1:0]  entry_index,
  input  wire logic [bmlp_pkg::VALUE_W-1:0]  entry_value,
  input  wire logic                          is_ipv4,
  input  wire logic [bmlp_pkg::FIELD_W-1:0]  total_length,
  input  wire logic [bmlp_pkg::FIELD_W-1:0]  tcp_window,
  // result channel
  output logic                               result_valid,
  input  wire logic                          result_ready,
  output logic                               drop,
  output logic                               classified,
  output logic signed [bmlp_pkg::SCORE_W-1:0] score,
  output logic [bmlp_pkg::COUNT_W-1:0]       packets_classified,
  output logic [bmlp_pkg::COUNT_W-1:0]       packets_dropped
);

  bmlp_pkg::state_t state, state_next;
  logic [bmlp_pkg::HID_CNT_W-1:0] cnt, cnt_next;

  // latched transaction
  logic                          is_cls;
  logic [bmlp_pkg::FIELD_W-1:0]  len;
  logic [bmlp_pkg::FIELD_W-1:0]  win;

  // layer activations; hidden layers fill by shifting in from the top
  logic [bmlp_pkg::FEATURE_COUNT-1:0] a0;
  logic [bmlp_pkg::HIDDEN_COUNT-1:0]  a1, a2;
  logic [bmlp_pkg::SCORE_W-1:0]       score_acc;

  logic [bmlp_pkg::COUNT_W-1:0] classified_count, dropped_count;
  logic [bmlp_pkg::COUNT_W-1:0] classified_count_next, dropped_count_next;

  logic item_accept;
  logic out_load;
  logic eval_hidden;

  bmlp_pkg::tbl_wr_t tbl_wr;
  bmlp_pkg::tbl_rd_t tbl_rd;
  bmlp_pkg::row_t    row;
  logic [bmlp_pkg::FEATURE_COUNT-1:0][bmlp_pkg::FTHR_W-1:0] feat_thr;
  logic [bmlp_pkg::HIDDEN_COUNT-1:0] out_weight;

  // neuron unit operands
  logic [bmlp_pkg::VEC_W-1:0]        nu_act, nu_weight;
  logic [bmlp_pkg::CNT_W-1:0]        nu_bits;
  logic signed [bmlp_pkg::THR_W-1:0] nu_thr;
  logic signed [bmlp_pkg::DOT_W-1:0] nu_dot;
  logic                              nu_fire;

  logic [bmlp_pkg::FEATURE_COUNT-1:0] feat_bits;

  // no transaction is taken while reset is held
  assign item_ready  = (state == bmlp_pkg::ST_IDLE) && !rst;
  assign item_accept = item_valid && item_ready;

  // table writes land in the accept cycle
  assign tbl_wr.en    = item_accept && (action == bmlp_pkg::ACTION_WRITE);
  assign tbl_wr.sel   = table_select;
  assign tbl_wr.idx   = entry_index;
  assign tbl_wr.value = entry_value;

  bmlp_tables u_tables (
    .clk        (clk),
    .rst        (rst),
    .wr         (tbl_wr),
    .rd         (tbl_rd),
    .feat_thr   (feat_thr),
    .out_weight (out_weight),
    .row        (row)
  );

  bmlp_neuron u_neuron (
    .act       (nu_act),
    .weight    (nu_weight),
    .bits_used (nu_bits),
    .thr       (nu_thr),
    .dot       (nu_dot),
    .fire      (nu_fire)
  );

  // feature bits: length everywhere except window at 1 and zero at 2, 3 and above 9
  always_comb begin
    logic [bmlp_pkg::FIELD_W-1:0] fval;
    fval = '0;
    for (int i = 0; i < bmlp_pkg::FEATURE_COUNT; i++) begin
      if (i == 1) fval = win;
      else if (i == 2 || i == 3 || i > 9) fval = '0;
      else fval = len;
      feat_bits[i] = {1'b0, fval} >= feat_thr[i];
    end
  end

  // sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bmlp_pkg::ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  // next state and neuron operand steering; a row read issued at count c
  // is evaluated at count c+1, so each hidden layer counts from 0 to HIDDEN_COUNT
  always_comb begin
    state_next    = state;
    cnt_next      = cnt;
    out_load      = 1'b0;
    eval_hidden   = 1'b0;
    tbl_rd.layer2 = (state == bmlp_pkg::ST_L2);
    tbl_rd.addr   = cnt[bmlp_pkg::HID_IDX_W-1:0];
    nu_act        = '0;
    nu_weight     = row.weight;
    nu_bits       = bmlp_pkg::CNT_W'(bmlp_pkg::HIDDEN_COUNT);
    nu_thr        = signed'(row.thr);
    unique case (state)
      bmlp_pkg::ST_IDLE: begin
        if (item_valid) begin
          cnt_next = '0;
          if (action == bmlp_pkg::ACTION_CLASSIFY && is_ipv4) state_next = bmlp_pkg::ST_FEAT;
          else state_next = bmlp_pkg::ST_FIN;
        end
      end
      bmlp_pkg::ST_FEAT: begin
        state_next = bmlp_pkg::ST_L1;
      end
      bmlp_pkg::ST_L1: begin
        nu_act      = bmlp_pkg::VEC_W'(a0);
        nu_bits     = bmlp_pkg::CNT_W'(bmlp_pkg::FEATURE_COUNT);
        eval_hidden = (cnt != '0);
        if (cnt == bmlp_pkg::HID_CNT_W'(bmlp_pkg::HIDDEN_COUNT)) begin
          cnt_next   = '0;
          state_next = bmlp_pkg::ST_L2;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      bmlp_pkg::ST_L2: begin
        nu_act      = bmlp_pkg::VEC_W'(a1);
        eval_hidden = (cnt != '0);
        if (cnt == bmlp_pkg::HID_CNT_W'(bmlp_pkg::HIDDEN_COUNT)) begin
          cnt_next   = '0;
          state_next = bmlp_pkg::ST_OUT;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      bmlp_pkg::ST_OUT: begin
        // output neuron: only the dot product is used
        nu_act     = bmlp_pkg::VEC_W'(a2);
        nu_weight  = bmlp_pkg::VEC_W'(out_weight);
        nu_thr     = '0;
        state_next = bmlp_pkg::ST_FIN;
      end
      bmlp_pkg::ST_FIN: begin
        // wait for the output register to free up
        if (!result_valid || result_ready) begin
          out_load   = 1'b1;
          state_next = bmlp_pkg::ST_IDLE;
        end
      end
      default: state_next = bmlp_pkg::ST_IDLE;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (item_accept) begin
      is_cls    <= (action == bmlp_pkg::ACTION_CLASSIFY) && is_ipv4;
      len       <= total_length;
      win       <= tcp_window;
      score_acc <= '0;
    end
    if (state == bmlp_pkg::ST_FEAT) a0 <= feat_bits;
    if (state == bmlp_pkg::ST_L1 && eval_hidden) begin
      a1 <= (a1 >> 1) | (bmlp_pkg::HIDDEN_COUNT'(nu_fire) << (bmlp_pkg::HIDDEN_COUNT - 1));
    end
    if (state == bmlp_pkg::ST_L2 && eval_hidden) begin
      a2 <= (a2 >> 1) | (bmlp_pkg::HIDDEN_COUNT'(nu_fire) << (bmlp_pkg::HIDDEN_COUNT - 1));
    end
    if (state == bmlp_pkg::ST_OUT) score_acc <= nu_dot[bmlp_pkg::SCORE_W-1:0];
  end

  // packet counters; drop when the score is not negative
  always_comb begin
    classified_count_next = classified_count;
    dropped_count_next    = dropped_count;
    if (is_cls) begin
      classified_count_next = classified_count + 1'b1;
      if (!score_acc[bmlp_pkg::SCORE_W-1]) dropped_count_next = dropped_count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      classified_count <= '0;
      dropped_count    <= '0;
    end else if (out_load) begin
      classified_count <= classified_count_next;
      dropped_count    <= dropped_count_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      drop               <= is_cls && !score_acc[bmlp_pkg::SCORE_W-1];
      classified         <= is_cls;
      score              <= signed'(score_acc);
      packets_classified <= classified_count_next;
      packets_dropped    <= dropped_count_next;
    end
  end

  // an unclassified transaction never reports a drop or a score
  a_unclassified_clean: assert property (@(posedge clk) disable iff (rst)
    result_valid && !classified |-> !drop && score == '0)
    else $error("unclassified result carries drop or score");

  // drop follows the sign of the score
  a_drop_sign: assert property (@(posedge clk) disable iff (rst)
    result_valid && classified |-> drop == !score[bmlp_pkg::SCORE_W-1])
    else $error("drop disagrees with score sign");

  // the classified counter steps by one per classified transaction only
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    out_load |=> classified_count ==
      $past(classified_count) + bmlp_pkg::COUNT_W'($past(is_cls)))
    else $error("classified counter stepped wrongly");

  // write and non-IPv4 transactions leave the drop counter alone
  a_drop_count: assert property (@(posedge clk) disable iff (rst)
    out_load && !is_cls |=> $stable(dropped_count))
    else $error("drop counter moved on unclassified transaction");

  // the neuron counter never runs past the layer length
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    state == bmlp_pkg::ST_L1 || state == bmlp_pkg::ST_L2 |->
      cnt <= bmlp_pkg::HID_CNT_W'(bmlp_pkg::HIDDEN_COUNT))
    else $error("neuron counter out of range");

endmodule
`default_nettype wire
